// ===== sv/rbes_pkg.sv =====
// ----------------------------------------------------------------------------
// Rigid body Euler step package
// Shared types and constants for the integrator and its multiply unit.
// ----------------------------------------------------------------------------
package rbes_pkg;

    typedef enum logic [2:0] {
        OP_STEP     = 3'd0,
        OP_ADD_FORCE = 3'd1,
        OP_SET_VEL  = 3'd2,
        OP_SET_ACC  = 3'd3,
        OP_SET_POS  = 3'd4
    } opcode_t;

    localparam logic [2:0] REG_MODE     = 3'd0;
    localparam logic [2:0] REG_MASS     = 3'd1;
    localparam logic [2:0] REG_INV_MASS = 3'd2;
    localparam logic [2:0] REG_GRAV_X   = 3'd3;
    localparam logic [2:0] REG_GRAV_Y   = 3'd4;
    localparam logic [2:0] REG_GRAV_Z   = 3'd5;
    localparam logic [2:0] REG_DRAG     = 3'd6;
    localparam logic [2:0] REG_FRICTION = 3'd7;

    localparam int DT_BITS = 16;

    // Start request to the multiply unit.
    typedef struct packed {
        logic               start;
        logic signed [32:0] a;
        logic signed [32:0] b;
        logic [4:0]         shift;
    } mul_req_t;

    // Saturate a 66-bit value to 32 bits.
    function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
        logic signed [65:0] hi;
        logic signed [65:0] lo;
        hi = 66'sd2147483647;
        lo = -66'sd2147483648;
        if (x > hi) return 32'sh7fffffff;
        if (x < lo) return 32'sh80000000;
        return x[31:0];
    endfunction

    function automatic logic signed [31:0] add_sat(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
        logic signed [32:0] s;
        s = 33'(a) + 33'(b);
        if (s[32] != s[31]) return s[32] ? 32'sh80000000 : 32'sh7fffffff;
        return s[31:0];
    endfunction

    // Saturating a - b; subtracting the most negative value from a non-negative a saturates high.
    function automatic logic signed [31:0] sub_sat(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
        logic signed [32:0] s;
        s = 33'(a) - 33'(b);
        if (s[32] != s[31]) return s[32] ? 32'sh80000000 : 32'sh7fffffff;
        return s[31:0];
    endfunction

endpackage

// ===== sv/rbes_mul.sv =====
// ----------------------------------------------------------------------------
// Rigid body Euler step multiply unit
// Registered signed multiply, arithmetic shift (floor) and saturation.
// The product is registered, then shifted and saturated into the result register, marked by done.
// ----------------------------------------------------------------------------
module rbes_mul (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  rbes_pkg::mul_req_t       req,
    output logic                     done,
    output logic signed [31:0]       result
);
    import rbes_pkg::*;

    logic signed [65:0] prod_reg;
    logic [4:0]         shift_reg;
    logic               busy_reg;
    logic               done_reg;
    logic signed [31:0] result_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= req.start;
            done_reg <= busy_reg;
        end
        if (req.start) begin
            prod_reg  <= req.a * req.b;
            shift_reg <= req.shift;
        end
        if (busy_reg) begin
            result_reg <= sat32(prod_reg >>> shift_reg);
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

// ===== sv/rigid_body_euler_step.sv =====
// ----------------------------------------------------------------------------
// Rigid body Euler step
// Semi-implicit Euler integrator of one 3D body with gravity, drag, friction.
// ----------------------------------------------------------------------------
// Timing: for set, add and unused opcodes the accepting edge leads to S_OUT,
// which registers m_tvalid. A step runs the speed sum, the square root, then the
// force, acceleration, velocity and position stages on the single shared multiply
// unit (disabled stages skipped), then a second speed sum and S_FIN before S_OUT.
// Throughput: one transaction at a time; s_tready is low while one is in work or its result waits.
// Reset: aresetn is synchronous and active low; state clears to zero,
// mass and inverse mass to one.
module rigid_body_euler_step #(
    parameter int FRAC_BITS = 16
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    // opcode[2:0], vec_x[34:3], vec_y[66:35], vec_z[98:67], delta_time[114:99]
    input  logic [119:0]  s_tdata,
    output logic          m_tvalid,
    input  logic          m_tready,
    // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, 32 bits each from bit 0
    output logic [191:0]  m_tdata,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [2:0]    cfg_index,
    input  logic [31:0]   cfg_data
);
    import rbes_pkg::*;

    localparam logic [4:0] FB = 5'(FRAC_BITS);
    localparam logic signed [31:0] SPEED_MIN = 32'((((64'sd35) <<< FRAC_BITS) + 500) / 1000);
    localparam logic signed [31:0] VY_MIN =
        32'(-((((64'sd981) <<< FRAC_BITS) + 50) / 100));
    localparam logic [63:0] SPEED_MIN_SQ = 64'(SPEED_MIN) * 64'(SPEED_MIN);

    typedef enum logic [3:0] {
        S_IDLE, S_SQ, S_SQRT, S_GRAV, S_KS, S_DRAG, S_MM, S_FRIC,
        S_ACC, S_VEL, S_POS, S_FIN, S_OUT
    } state_t;

    state_t state_reg;
    logic [3:0]  mode_reg;
    logic [30:0] mass_reg, inv_mass_reg, drag_reg, fric_reg;
    logic signed [31:0] grav_reg [3];
    logic signed [31:0] pos_reg [3];
    logic signed [31:0] vel_reg [3];
    logic signed [31:0] acc_reg [3];
    logic signed [31:0] frc_reg [3];
    logic [15:0] dt_reg;
    logic [1:0]  idx_reg;
    logic        wait_reg;
    logic signed [31:0] coef_reg;
    logic [63:0] sq_reg, rem_reg, root_reg;
    logic [5:0]  cnt_reg;
    logic        out_valid_reg;
    // Marks that the velocity/position update is complete.
    logic        dt_done_reg;

    mul_req_t req;
    logic mdone;
    logic signed [31:0] mres;
    logic   skip;
    state_t skip_next;

    rbes_mul u_mul (.aclk(aclk), .aresetn(aresetn), .req(req), .done(mdone), .result(mres));

    assign s_tready  = (state_reg == S_IDLE) && !out_valid_reg;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            m_tdata[32*i +: 32]     = pos_reg[i];
            m_tdata[96 + 32*i +: 32] = vel_reg[i];
        end
    end

    // Disabled stages are passed over without touching the multiplier.
    always_comb begin
        skip = 1'b0;
        skip_next = state_reg;
        unique case (state_reg)
            S_GRAV: begin
                skip = !mode_reg[0];
                skip_next = mode_reg[1] ? S_KS : S_MM;
            end
            S_KS, S_DRAG: begin
                skip = !mode_reg[1];
                skip_next = S_MM;
            end
            S_MM, S_FRIC: begin
                skip = !mode_reg[2];
                skip_next = S_ACC;
            end
            S_ACC: begin
                skip = mode_reg[3];
                skip_next = S_VEL;
            end
            default: ;
        endcase
    end

    // One operand pair per state for the shared multiplier.
    always_comb begin
        req.start = !wait_reg && !skip;
        req.a = 33'sd0;
        req.b = 33'sd0;
        req.shift = FB;
        unique case (state_reg)
            S_GRAV: begin req.a = 33'(grav_reg[idx_reg]); req.b = {2'b0, mass_reg}; end
            // The speed is capped at the largest signed 32-bit value.
            S_KS:   begin req.a = {2'b0, drag_reg};
                          req.b = (root_reg > 64'h7fffffff) ? 33'h07fffffff :
                                                              {1'b0, root_reg[31:0]}; end
            S_DRAG, S_FRIC: begin req.a = 33'(coef_reg); req.b = 33'(vel_reg[idx_reg]); end
            S_MM:   begin req.a = {2'b0, fric_reg}; req.b = {2'b0, mass_reg}; end
            S_ACC:  begin req.a = 33'(frc_reg[idx_reg]); req.b = {2'b0, inv_mass_reg}; end
            S_VEL:  begin req.a = 33'(acc_reg[idx_reg]); req.b = {17'b0, dt_reg};
                          req.shift = 5'(DT_BITS); end
            S_POS:  begin req.a = 33'(vel_reg[idx_reg]); req.b = {17'b0, dt_reg};
                          req.shift = 5'(DT_BITS); end
            default: req.start = 1'b0;
        endcase
    end

    logic signed [63:0] vsq;
    assign vsq = 64'(vel_reg[idx_reg]) * 64'(vel_reg[idx_reg]);
    logic [63:0] bit_w, trial;
    assign bit_w = 64'd1 << {cnt_reg[4:0], 1'b0};
    assign trial = root_reg + bit_w;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            out_valid_reg <= 1'b0;
            wait_reg <= 1'b0;
            mode_reg <= 4'd0;
            mass_reg <= 31'(64'd1 << FRAC_BITS);
            inv_mass_reg <= 31'(64'd1 << FRAC_BITS);
            drag_reg <= '0;
            fric_reg <= '0;
            for (int i = 0; i < 3; i++) begin
                grav_reg[i] <= '0; pos_reg[i] <= '0; vel_reg[i] <= '0;
                acc_reg[i] <= '0; frc_reg[i] <= '0;
            end
        end else begin
            if (cfg_valid) begin
                unique case (cfg_index)
                    REG_MODE:     mode_reg <= cfg_data[3:0];
                    REG_MASS:     mass_reg <= cfg_data[30:0];
                    REG_INV_MASS: inv_mass_reg <= cfg_data[30:0];
                    REG_GRAV_X:   grav_reg[0] <= cfg_data;
                    REG_GRAV_Y:   grav_reg[1] <= cfg_data;
                    REG_GRAV_Z:   grav_reg[2] <= cfg_data;
                    REG_DRAG:     drag_reg <= cfg_data[30:0];
                    REG_FRICTION: fric_reg <= cfg_data[30:0];
                    default: ;
                endcase
            end
            if (out_valid_reg && m_tready) out_valid_reg <= 1'b0;
            // Multiply states issue one product, then wait for it.
            if (req.start) wait_reg <= 1'b1;
            unique case (state_reg)
                S_IDLE: if (s_tvalid && s_tready) begin
                    dt_reg <= s_tdata[114:99];
                    idx_reg <= 2'd0;
                    sq_reg <= '0;
                    state_reg <= (s_tdata[2:0] == OP_STEP) ? S_SQ : S_OUT;
                    case (s_tdata[2:0])
                        OP_STEP: ;
                        OP_ADD_FORCE: for (int i = 0; i < 3; i++)
                            frc_reg[i] <= add_sat(frc_reg[i], s_tdata[3+32*i +: 32]);
                        OP_SET_VEL: for (int i = 0; i < 3; i++) vel_reg[i] <= s_tdata[3+32*i +: 32];
                        OP_SET_ACC: for (int i = 0; i < 3; i++) acc_reg[i] <= s_tdata[3+32*i +: 32];
                        OP_SET_POS: for (int i = 0; i < 3; i++) pos_reg[i] <= s_tdata[3+32*i +: 32];
                        default: ;
                    endcase
                end
                S_SQ: begin
                    // The second pass after S_POS computes the new speed.
                    sq_reg <= sq_reg + 64'(vsq);
                    if (idx_reg == 2'd2) begin
                        idx_reg <= 2'd0;
                        rem_reg <= sq_reg + 64'(vsq);
                        root_reg <= '0;
                        cnt_reg <= 6'd31;
                        state_reg <= dt_done_reg ? S_FIN : S_SQRT;
                    end else idx_reg <= idx_reg + 2'd1;
                end
                S_SQRT: begin
                    // One result bit per cycle, restoring square root.
                    if (rem_reg >= trial) begin
                        rem_reg <= rem_reg - trial;
                        root_reg <= (root_reg >> 1) + bit_w;
                    end else root_reg <= root_reg >> 1;
                    cnt_reg <= cnt_reg - 6'd1;
                    if (cnt_reg == 6'd0) state_reg <= S_GRAV;
                end
                S_FIN: begin
                    for (int i = 0; i < 3; i++) if (!mode_reg[3]) begin
                        acc_reg[i] <= '0; frc_reg[i] <= '0;
                    end
                    if (sq_reg < SPEED_MIN_SQ) for (int i = 0; i < 3; i++) vel_reg[i] <= '0;
                    if (vel_reg[1] < VY_MIN) begin
                        vel_reg[0] <= '0; vel_reg[1] <= VY_MIN; vel_reg[2] <= '0;
                    end
                    state_reg <= S_OUT;
                end
                S_OUT: begin
                    out_valid_reg <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default: begin
                    if (skip) begin
                        wait_reg <= 1'b0;
                        state_reg <= skip_next;
                    end else if (mdone) begin
                        wait_reg <= 1'b0;
                        if (state_reg == S_KS || state_reg == S_MM) begin
                            coef_reg <= mres;
                            state_reg <= state_t'(state_reg + 4'd1);
                        end else begin
                            unique case (state_reg)
                                S_GRAV: frc_reg[idx_reg] <= add_sat(frc_reg[idx_reg], mres);
                                S_DRAG, S_FRIC: frc_reg[idx_reg] <=
                                    sub_sat(frc_reg[idx_reg], mres);
                                S_ACC: acc_reg[idx_reg] <= add_sat(acc_reg[idx_reg], mres);
                                S_VEL: vel_reg[idx_reg] <= add_sat(vel_reg[idx_reg], mres);
                                default: pos_reg[idx_reg] <= add_sat(pos_reg[idx_reg], mres);
                            endcase
                            if (idx_reg == 2'd2) begin
                                idx_reg <= 2'd0;
                                if (state_reg == S_POS) sq_reg <= '0;
                                state_reg <= (state_reg == S_POS) ? S_SQ :
                                             state_t'(state_reg + 4'd1);
                            end else idx_reg <= idx_reg + 2'd1;
                        end
                    end
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) dt_done_reg <= 1'b0;
        else if (state_reg == S_IDLE) dt_done_reg <= 1'b0;
        else if (state_reg == S_POS && mdone && idx_reg == 2'd2) dt_done_reg <= 1'b1;
    end

    // No input is taken while a result waits on the output.
    assert property (@(posedge aclk) disable iff (!aresetn) !(m_tvalid && s_tready))
        else $error("input accepted while a result is pending");

    // The input stays closed while a transaction is in work.
    assert property (@(posedge aclk) disable iff (!aresetn)
                     (state_reg != S_IDLE) |-> !s_tready)
        else $error("ready while busy");

    // A stalled result holds its valid and its data.
    assert property (@(posedge aclk) disable iff (!aresetn)
                     (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result changed while stalled");

endmodule
